// ----- src/tss_pkg.sv -----
// Shared types, codes and defaults for the task slot scheduler.
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

  // Default configuration.
  localparam int SLOT_COUNT_DEF = 16;
  localparam int ID_BITS_DEF    = 32;

  // Action codes carried in the input word.
  localparam logic [2:0] ACT_CREATE   = 3'd0;
  localparam logic [2:0] ACT_READY    = 3'd1;
  localparam logic [2:0] ACT_YIELD    = 3'd2;
  localparam logic [2:0] ACT_BLOCK    = 3'd3;
  localparam logic [2:0] ACT_RESUME   = 3'd4;
  localparam logic [2:0] ACT_SCHEDULE = 3'd5;
  localparam logic [2:0] ACT_DESTROY  = 3'd6;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_BUSY    = 2'd3
  } stat_t;

  // Per-slot life cycle. Nothing enters the done state, but ready must skip it.
  typedef enum logic [2:0] {
    SLOT_FREE    = 3'd0,
    SLOT_CREATED = 3'd1,
    SLOT_READY   = 3'd2,
    SLOT_RUNNING = 3'd3,
    SLOT_BLOCKED = 3'd4,
    SLOT_DONE    = 3'd5
  } slot_st_t;

  // Input word.
  typedef struct packed {
    logic [2:0] action;
    logic [3:0] target_slot;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  result_slot;
    logic [31:0] task_id;
    logic        has_current;
    logic [3:0]  current_slot;
    logic [4:0]  ready_count;
    logic [4:0]  live_count;
  } out_t;

  // Ready queue operations requested for one action.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

endpackage
`default_nettype wire

// ----- src/tss_ready_fifo.sv -----
// Ready queue of slot indices with a registered head read.
`timescale 1ns / 1ps
`default_nettype none
module tss_ready_fifo #(
  parameter int SLOT_COUNT = tss_pkg::SLOT_COUNT_DEF,
  parameter int IW         = $clog2(SLOT_COUNT),
  parameter int CW         = $clog2(SLOT_COUNT + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tss_pkg::fifo_ctl_t ctl,
  input  wire logic [IW-1:0]     push_data,
  output logic      [IW-1:0]     head_val,
  output logic      [CW-1:0]     count
);
  import tss_pkg::*;

  logic [IW-1:0] mem [SLOT_COUNT];
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] rd_r, rd_nxt;

  // Pointer advance with wrap at the table size.
  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    wrap_inc = (p == IW'(SLOT_COUNT - 1)) ? '0 : p + 1'b1;
  endfunction

  // Next pointers and occupancy.
  always_comb begin
    head_nxt  = ctl.pop ? wrap_inc(head_r) : head_r;
    tail_nxt  = ctl.push ? wrap_inc(tail_r) : tail_r;
    count_nxt = count_r + CW'(ctl.push) - CW'(ctl.pop);
    rd_nxt    = (ctl.push && (tail_r == head_nxt)) ? push_data : mem[head_nxt];
  end

  // The head comes straight from the registered read; it is valid while the queue holds a word.
  assign head_val = rd_r;
  assign count    = count_r;

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage and registered head read.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= push_data;
    end
    rd_r <= rd_nxt;
  end

endmodule
`default_nettype wire

// ----- src/tss_id_store.sv -----
// Task identifier memory with one write port and a registered read.
`timescale 1ns / 1ps
`default_nettype none
module tss_id_store #(
  parameter int SLOT_COUNT = tss_pkg::SLOT_COUNT_DEF,
  parameter int ID_BITS    = tss_pkg::ID_BITS_DEF,
  parameter int IW         = $clog2(SLOT_COUNT)
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [IW-1:0]      waddr,
  input  wire logic [ID_BITS-1:0] wdata,
  input  wire logic [IW-1:0]      raddr,
  output logic      [ID_BITS-1:0] rdata
);
  import tss_pkg::*;

  logic [ID_BITS-1:0] mem [SLOT_COUNT];
  logic [ID_BITS-1:0] rd_r;

  // Write-first read so the result shows the value after this action.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= (we && (waddr == raddr)) ? wdata : mem[raddr];
  end

  assign rdata = rd_r;

endmodule
`default_nettype wire

// ----- src/tss_ctrl.sv -----
// Slot table, current task, counters and the result register.
`timescale 1ns / 1ps
`default_nettype none
module tss_ctrl #(
  parameter int SLOT_COUNT = tss_pkg::SLOT_COUNT_DEF,
  parameter int ID_BITS    = tss_pkg::ID_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         act_vld,
  input  wire tss_pkg::in_t act_in,
  output logic              res_vld,
  output tss_pkg::out_t     res
);
  import tss_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);

  // Slot table and scheduler state.
  slot_st_t             st_r [SLOT_COUNT];
  slot_st_t             st_nxt [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] q_r, q_nxt;
  logic                 cur_vld_r, cur_vld_nxt;
  logic [IW-1:0]        cur_idx_r, cur_idx_nxt;
  logic [ID_BITS-1:0]   nid_r, nid_nxt;
  logic [CW-1:0]        live_r, live_nxt;

  // Result register.
  logic                 res_vld_r;
  out_t                 res_r, res_nxt;
  logic                 id_ok_r, id_ok_nxt;

  // Queue and identifier store ports.
  fifo_ctl_t            fctl;
  logic [IW-1:0]        f_wdata, f_head;
  logic [CW-1:0]        f_count;
  logic                 id_we;
  logic [ID_BITS-1:0]   id_rdata;

  // Decode and working values.
  logic                 tvalid;
  logic [IW-1:0]        tidx;
  logic                 free_found;
  logic [IW-1:0]        free_idx;
  logic                 can_q;
  logic                 run_req, sched;
  logic [IW-1:0]        rslot;
  logic                 rvalid;
  logic [IW-1:0]        pop_slot;
  stat_t                status;

  assign tvalid = 32'(act_in.target_slot) < SLOT_COUNT;
  assign tidx   = IW'(act_in.target_slot);

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (st_r[i] == SLOT_FREE) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // One action: table updates, queue operations and the result fields.
  always_comb begin
    st_nxt      = st_r;
    q_nxt       = q_r;
    cur_vld_nxt = cur_vld_r;
    cur_idx_nxt = cur_idx_r;
    nid_nxt     = nid_r;
    live_nxt    = live_r;
    fctl        = '0;
    f_wdata     = tidx;
    id_we       = 1'b0;
    status      = STAT_IGNORED;
    rslot       = tidx;
    rvalid      = tvalid;
    run_req     = 1'b0;
    sched       = 1'b0;
    // An empty queue can only pop the current slot that a yield pushes in the same action.
    pop_slot    = (f_count == '0) ? cur_idx_r : f_head;
    can_q       = 1'b0;

    if (act_vld) begin
      unique case (act_in.action)
        ACT_CREATE: begin
          rslot  = '0;
          rvalid = 1'b0;
          status = STAT_FULL;
          if (free_found) begin
            st_nxt[free_idx] = SLOT_CREATED;
            q_nxt[free_idx]  = 1'b0;
            id_we            = 1'b1;
            nid_nxt          = nid_r + 1'b1;
            live_nxt         = live_r + 1'b1;
            rslot            = free_idx;
            rvalid           = 1'b1;
            status           = STAT_DONE;
          end
        end
        ACT_READY, ACT_RESUME: begin
          can_q = !q_r[tidx] && (f_count < CW'(SLOT_COUNT));
          if (tvalid && can_q &&
              (((act_in.action == ACT_READY) && (st_r[tidx] != SLOT_FREE) &&
                (st_r[tidx] != SLOT_DONE)) ||
               ((act_in.action == ACT_RESUME) && (st_r[tidx] == SLOT_BLOCKED)))) begin
            st_nxt[tidx] = SLOT_READY;
            q_nxt[tidx]  = 1'b1;
            fctl.push    = 1'b1;
            status       = STAT_DONE;
          end
        end
        ACT_YIELD, ACT_BLOCK: begin
          if (!cur_vld_r) begin
            rslot  = '0;
            rvalid = 1'b0;
          end else begin
            rslot   = cur_idx_r;
            rvalid  = 1'b1;
            f_wdata = cur_idx_r;
            can_q   = !q_r[cur_idx_r] && (f_count < CW'(SLOT_COUNT));
            if (act_in.action == ACT_YIELD) begin
              if ((st_r[cur_idx_r] == SLOT_RUNNING) && can_q) begin
                st_nxt[cur_idx_r] = SLOT_READY;
                q_nxt[cur_idx_r]  = 1'b1;
                fctl.push         = 1'b1;
              end
            end else begin
              st_nxt[cur_idx_r] = SLOT_BLOCKED;
            end
            run_req = 1'b1;
            status  = STAT_DONE;
          end
        end
        ACT_SCHEDULE: begin
          run_req = 1'b1;
          sched   = 1'b1;
          status  = STAT_DONE;
        end
        ACT_DESTROY: begin
          if (tvalid && (st_r[tidx] != SLOT_FREE)) begin
            if (q_r[tidx]) begin
              status = STAT_BUSY;
            end else begin
              st_nxt[tidx] = SLOT_FREE;
              live_nxt     = live_r - 1'b1;
              if (cur_vld_r && (cur_idx_r == tidx)) begin
                cur_vld_nxt = 1'b0;
                cur_idx_nxt = '0;
              end
              status = STAT_DONE;
            end
          end
        end
        default: begin
        end
      endcase

      // Take the queue head as the new current task, or clear current.
      if (run_req) begin
        if ((f_count != '0) || fctl.push) begin
          fctl.pop         = 1'b1;
          st_nxt[pop_slot] = SLOT_RUNNING;
          q_nxt[pop_slot]  = 1'b0;
          cur_vld_nxt      = 1'b1;
          cur_idx_nxt      = pop_slot;
        end else begin
          cur_vld_nxt = 1'b0;
          cur_idx_nxt = '0;
        end
      end
      if (sched) begin
        rslot  = cur_idx_nxt;
        rvalid = cur_vld_nxt;
      end
    end
  end

  // Result fields; the identifier arrives from the store's registered read.
  always_comb begin
    id_ok_nxt            = rvalid && (st_nxt[rslot] != SLOT_FREE);
    res_nxt              = '0;
    res_nxt.status       = status;
    res_nxt.result_slot  = 4'(rslot);
    res_nxt.has_current  = cur_vld_nxt;
    res_nxt.current_slot = 4'(cur_idx_nxt);
    res_nxt.ready_count  = 5'(f_count + CW'(fctl.push) - CW'(fctl.pop));
    res_nxt.live_count   = 5'(live_nxt);
  end

  tss_ready_fifo #(
    .SLOT_COUNT (SLOT_COUNT),
    .IW         (IW),
    .CW         (CW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fctl),
    .push_data (f_wdata),
    .head_val  (f_head),
    .count     (f_count)
  );

  tss_id_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .ID_BITS    (ID_BITS),
    .IW         (IW)
  ) u_ids (
    .clk   (clk),
    .we    (id_we),
    .waddr (free_idx),
    .wdata (nid_r),
    .raddr (rslot),
    .rdata (id_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        st_r[i] <= SLOT_FREE;
      end
      q_r       <= '0;
      cur_vld_r <= 1'b0;
      cur_idx_r <= '0;
      nid_r     <= ID_BITS'(1);
      live_r    <= '0;
      res_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      q_r       <= q_nxt;
      cur_vld_r <= cur_vld_nxt;
      cur_idx_r <= cur_idx_nxt;
      nid_r     <= nid_nxt;
      live_r    <= live_nxt;
      res_vld_r <= act_vld;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (act_vld) begin
      res_r   <= res_nxt;
      id_ok_r <= id_ok_nxt;
    end
  end

  always_comb begin
    res         = res_r;
    res.task_id = id_ok_r ? 32'(id_rdata) : '0;
  end

  assign res_vld = res_vld_r;

endmodule
`default_nettype wire

// ----- src/task_slot_scheduler.sv -----
// Top level of the task slot scheduler: input register and result strobe.
//
//   channel  ports                    handshake
//   input    start, busy, in_data     word taken when start is high and busy is low
//   result   out_valid, out_data      word shown for one cycle while out_valid is high
//
// Each word passes from acceptance into the input register, then through the slot
// table logic into the result register. A new word can be taken every cycle while
// busy is low, so the sustained rate is one per cycle, set by the single pass
// through the lowest-free search and queue update.
// Busy is high while reset is held and in the one cycle that follows it.
// Reset clears the slot table, the queue pointers and the current task.
// The receiver cannot stall; every result is delivered on its strobe.
`timescale 1ns / 1ps
`default_nettype none
module task_slot_scheduler #(
  parameter int SLOT_COUNT = tss_pkg::SLOT_COUNT_DEF,
  parameter int ID_BITS    = tss_pkg::ID_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire tss_pkg::in_t in_data,
  output logic              out_valid,
  output tss_pkg::out_t     out_data
);
  import tss_pkg::*;

  logic busy_r;
  logic in_vld_r;
  in_t  in_r;

  // Input register and acceptance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      in_vld_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      in_vld_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      in_r <= in_data;
    end
  end

  assign busy = busy_r;

  tss_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .ID_BITS    (ID_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .act_vld (in_vld_r),
    .act_in  (in_r),
    .res_vld (out_valid),
    .res     (out_data)
  );

endmodule
`default_nettype wire

// ----- src/tss_checker.sv -----
// Port-level checks for the task slot scheduler and their binding.
`timescale 1ns / 1ps
`default_nettype none
module tss_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire tss_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire tss_pkg::out_t out_data
);
  import tss_pkg::*;

  // Every accepted word yields exactly one result, after the input and result registers.
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word produced no result");

  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##2 !out_valid)
    else $error("result without an accepted word");

  // With no current task the reported slot is zero.
  a_idle_current : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_current) |-> (out_data.current_slot == 4'd0))
    else $error("current slot reported without a current task");

  // A full table reports slot zero and identifier zero.
  a_full_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STAT_FULL)) |->
      ((out_data.result_slot == 4'd0) && (out_data.task_id == 32'd0)))
    else $error("full status with a slot or identifier");

endmodule

bind task_slot_scheduler tss_checker u_tss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
